FILE: hdl/pressure_regulator_pid_pwm_unit_defines.svh
// ----------------------------------------------------------------------------
// Pressure regulator assertion macros
// Concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_REGULATOR_PID_PWM_UNIT_DEFINES_SVH
`define PRESSURE_REGULATOR_PID_PWM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define PRPP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the trigger
`define PRPP_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);

`else

`define PRPP_ASSERT(name, clk, rst_n, prop, msg)
`define PRPP_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg)

`endif

`endif

FILE: hdl/prpp_pkg.sv
// ----------------------------------------------------------------------------
// Pressure regulator package
// Shared widths, constants and inter-module structs.
// ----------------------------------------------------------------------------
package prpp_pkg;

    localparam int PRESS_W = 16;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 17;
    localparam int TSU_W   = 17;
    localparam int TSS_W   = 32;
    localparam int INTEG_W = 48;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int DERIV_W = 28;
    localparam int FS_W    = 42;
    localparam int WIDE_W  = 64;
    localparam int CNT_W   = 6;

    // shared unit operations
    localparam logic MDU_MUL = 1'b0;
    localparam logic MDU_DIV = 1'b1;

    // saturation bounds
    localparam logic signed [WIDE_W-1:0] FS_POS    = 64'sd1 <<< 40;
    localparam logic signed [WIDE_W-1:0] FS_NEG    = -(64'sd1 <<< 40);
    localparam logic signed [WIDE_W-1:0] ITERM_POS = 64'sd1 <<< 60;
    localparam logic signed [WIDE_W-1:0] ITERM_NEG = -(64'sd1 <<< 60);
    localparam logic [DUTY_W-1:0]        RATIO_FULL = 17'h10000;
    localparam logic [GAIN_W-1:0]        DERIV_SCALE = 16'd1000;

    typedef struct packed {
        logic               mode_select;
        logic [PRESS_W-1:0] limit_pressure;
        logic [PRESS_W-1:0] supply_start_pressure;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  period_ms;
    } prpp_cfg_t;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [WIDE_W-1:0] opa;
        logic [WIDE_W-1:0] opb;
    } prpp_mdu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WIDE_W-1:0] result;
    } prpp_mdu_rsp_t;

endpackage

FILE: hdl/prpp_if.sv
// ----------------------------------------------------------------------------
// Pressure regulator channel interfaces
// Valid/ready channels for sensor ticks and per-tick results.
// ----------------------------------------------------------------------------
interface prpp_in_if import prpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRESS_W-1:0] tank_a;
    logic [PRESS_W-1:0] tank_b;
    logic [PRESS_W-1:0] tank_c;
    logic [PRESS_W-1:0] supply_pressure;

    modport source (output valid, tank_a, tank_b, tank_c, supply_pressure, input ready);
    modport sink   (input valid, tank_a, tank_b, tank_c, supply_pressure, output ready);
endinterface

interface prpp_out_if import prpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               valve_open;
    logic               updated;
    logic [PRESS_W-1:0] fused_pressure;
    logic [PRESS_W-1:0] setpoint;
    logic [DUTY_W-1:0]  duty_fraction;

    modport source (output valid, valve_open, updated, fused_pressure, setpoint,
                    duty_fraction, input ready);
    modport sink   (input valid, valve_open, updated, fused_pressure, setpoint,
                    duty_fraction, output ready);
endinterface

FILE: hdl/prpp_regs.sv
// ----------------------------------------------------------------------------
// Pressure regulator configuration registers
// APB-style register file holding mode, limits, gains and period.
// ----------------------------------------------------------------------------
module prpp_regs import prpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output prpp_cfg_t   cfg
);

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_START  = 3'd2;
    localparam logic [2:0] REG_GAIN_P = 3'd3;
    localparam logic [2:0] REG_GAIN_I = 3'd4;
    localparam logic [2:0] REG_GAIN_D = 3'd5;
    localparam logic [2:0] REG_PERIOD = 3'd6;

    logic [2:0] idx;
    logic       wr_en;
    prpp_cfg_t  cfg_reg;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_select           <= 1'b0;
            cfg_reg.limit_pressure        <= 16'd6000;
            cfg_reg.supply_start_pressure <= 16'd30000;
            cfg_reg.gain_p                <= 16'd435;
            cfg_reg.gain_i                <= 16'd77;
            cfg_reg.gain_d                <= 16'd0;
            cfg_reg.period_ms             <= 16'd10;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODE:   cfg_reg.mode_select           <= pwdata[0];
                REG_LIMIT:  cfg_reg.limit_pressure        <= pwdata[PRESS_W-1:0];
                REG_START:  cfg_reg.supply_start_pressure <= pwdata[PRESS_W-1:0];
                REG_GAIN_P: cfg_reg.gain_p                <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: cfg_reg.gain_i                <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: cfg_reg.gain_d                <= pwdata[GAIN_W-1:0];
                REG_PERIOD: cfg_reg.period_ms             <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_MODE:   prdata = {31'b0, cfg_reg.mode_select};
            REG_LIMIT:  prdata = {16'b0, cfg_reg.limit_pressure};
            REG_START:  prdata = {16'b0, cfg_reg.supply_start_pressure};
            REG_GAIN_P: prdata = {16'b0, cfg_reg.gain_p};
            REG_GAIN_I: prdata = {16'b0, cfg_reg.gain_i};
            REG_GAIN_D: prdata = {16'b0, cfg_reg.gain_d};
            REG_PERIOD: prdata = {16'b0, cfg_reg.period_ms};
            default:    prdata = 32'b0;
        endcase
    end

endmodule

FILE: hdl/prpp_mdu.sv
// ----------------------------------------------------------------------------
// Pressure regulator multiply/divide unit
// Shift-add multiplier (16-bit multiplier) and restoring signed divider.
// ----------------------------------------------------------------------------
module prpp_mdu import prpp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  prpp_mdu_req_t req,
    output prpp_mdu_rsp_t rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;
    localparam logic [1:0] M_FIX  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              op_reg, op_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [WIDE_W-1:0] acc_reg, acc_next;
    logic [WIDE_W-1:0] sh_reg, sh_next;
    logic [WIDE_W-1:0] op2_reg, op2_next;
    logic [WIDE_W-1:0] res_reg, res_next;
    logic [WIDE_W-1:0] abs_a, abs_b;
    logic [WIDE_W:0]   trial;
    logic              ge;

    // operand magnitudes and one divide step
    assign abs_a = req.opa[WIDE_W-1] ? WIDE_W'(-req.opa) : req.opa;
    assign abs_b = req.opb[WIDE_W-1] ? WIDE_W'(-req.opb) : req.opb;
    assign trial = {acc_reg, sh_reg[WIDE_W-1]};
    assign ge    = trial >= {1'b0, op2_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        op2_next   = op2_reg;
        res_next   = res_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    acc_next = '0;
                    if (req.op == MDU_MUL)
                    begin
                        sh_next    = req.opa;
                        op2_next   = WIDE_W'(req.opb[GAIN_W-1:0]);
                        cnt_next   = CNT_W'(GAIN_W - 1);
                        state_next = M_MUL;
                    end
                    else
                    begin
                        sh_next    = abs_a;
                        op2_next   = abs_b;
                        neg_next   = req.opa[WIDE_W-1] ^ req.opb[WIDE_W-1];
                        cnt_next   = CNT_W'(WIDE_W - 1);
                        state_next = M_DIV;
                    end
                end
            end
            M_MUL:
            begin
                acc_next = acc_reg + (op2_reg[0] ? sh_reg : '0);
                sh_next  = sh_reg << 1;
                op2_next = op2_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = M_FIX;
            end
            M_DIV:
            begin
                acc_next = ge ? WIDE_W'(trial - {1'b0, op2_reg}) : trial[WIDE_W-1:0];
                sh_next  = {sh_reg[WIDE_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = M_FIX;
            end
            M_FIX:
            begin
                if (op_reg == MDU_MUL)
                    res_next = acc_reg;
                else
                    res_next = neg_reg ? WIDE_W'(-sh_reg) : sh_reg;
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            op_reg    <= MDU_MUL;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            neg_reg   <= neg_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        op2_reg <= op2_next;
        res_reg <= res_next;
    end

    assign rsp.busy   = (state_reg != M_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: hdl/prpp_core.sv
// ----------------------------------------------------------------------------
// Pressure regulator control sequencer
// Tick counters, sensor fusion, PID update steps and PWM valve decision.
// ----------------------------------------------------------------------------
`include "pressure_regulator_pid_pwm_unit_defines.svh"

module prpp_core import prpp_pkg::*;
#(
    parameter int RAMP_MS = 10000
)
(
    input  logic          clk,
    input  logic          rst_n,
    prpp_in_if.sink       in_ch,
    prpp_out_if.source    out_ch,
    input  prpp_cfg_t     cfg,
    output prpp_mdu_req_t req,
    input  prpp_mdu_rsp_t rsp
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RMUL   = 4'd1;
    localparam logic [3:0] ST_RDIV   = 4'd2;
    localparam logic [3:0] ST_ERR    = 4'd3;
    localparam logic [3:0] ST_FMUL   = 4'd4;
    localparam logic [3:0] ST_FDIV   = 4'd5;
    localparam logic [3:0] ST_IMUL   = 4'd6;
    localparam logic [3:0] ST_DMUL   = 4'd7;
    localparam logic [3:0] ST_DDIV   = 4'd8;
    localparam logic [3:0] ST_TMUL   = 4'd9;
    localparam logic [3:0] ST_PMUL   = 4'd10;
    localparam logic [3:0] ST_GMUL   = 4'd11;
    localparam logic [3:0] ST_DECIDE = 4'd12;
    localparam logic [3:0] ST_QDIV   = 4'd13;
    localparam logic [3:0] ST_WMUL   = 4'd14;

    logic [3:0]                 state_reg;
    logic                       issued_reg;
    logic [TSU_W-1:0]           tsu_reg;
    logic [TSS_W-1:0]           tss_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [DIFF_W-1:0]   prev_reg;
    logic [PRESS_W-1:0]         ramp_reg;
    logic [PRESS_W-1:0]         duty_ms_reg;
    logic [DUTY_W-1:0]          ratio_reg;
    logic [PRESS_W-1:0]         fused_reg;
    logic [PRESS_W-1:0]         sp_reg;
    logic [PRESS_W-1:0]         supply_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [FS_W-1:0]     fs_reg;
    logic signed [DERIV_W-1:0]  deriv_reg;
    logic signed [WIDE_W-1:0]   corr_reg;

    logic                       out_valid_reg;
    logic                       out_valve_reg;
    logic                       out_upd_reg;
    logic [PRESS_W-1:0]         out_fused_reg;
    logic [PRESS_W-1:0]         out_sp_reg;
    logic [DUTY_W-1:0]          out_duty_reg;

    logic                       in_acc;
    logic                       due;
    logic [TSU_W-1:0]           tsu_inc;
    logic [TSS_W-1:0]           tss_inc;
    logic [PRESS_W-1:0]         dab, dbc, dac;
    logic [PRESS_W:0]           sum_ab, sum_bc, sum_ac;
    logic [PRESS_W-1:0]         fused_now;
    logic signed [ERR_W-1:0]    den;
    logic signed [ERR_W-1:0]    err_now;
    logic signed [ERR_W-1:0]    supply_off;
    logic signed [DIFF_W-1:0]   err_diff;
    logic [GAIN_W-1:0]          per_div;
    logic signed [WIDE_W-1:0]   res_s;
    logic signed [WIDE_W-1:0]   fs_sum;
    logic signed [WIDE_W-1:0]   fs_sat;
    logic [INTEG_W:0]           integ_sum;
    logic signed [INTEG_W-1:0]  integ_sat;
    logic signed [WIDE_W-1:0]   iterm_sat;
    logic signed [WIDE_W-1:0]   fs8;
    logic [WIDE_W-1:0]          corr_shift;
    logic [33:0]                duty_sum;
    logic [PRESS_W-1:0]         duty_now;
    logic                       op_state;

    // handshake
    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_acc      = in_ch.valid && in_ch.ready;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.valve_open     = out_valve_reg;
    assign out_ch.updated        = out_upd_reg;
    assign out_ch.fused_pressure = out_fused_reg;
    assign out_ch.setpoint       = out_sp_reg;
    assign out_ch.duty_fraction  = out_duty_reg;

    // saturating tick counters and update trigger
    assign tsu_inc = (tsu_reg != '1) ? tsu_reg + 1'b1 : tsu_reg;
    assign tss_inc = (tss_reg != '1) ? tss_reg + 1'b1 : tss_reg;
    assign due     = tsu_inc > {1'b0, cfg.period_ms};

    // fusion: average the closest pair, ties go to a and b
    always_comb
    begin
        dab    = (in_ch.tank_a > in_ch.tank_b) ? in_ch.tank_a - in_ch.tank_b
                                               : in_ch.tank_b - in_ch.tank_a;
        dbc    = (in_ch.tank_b > in_ch.tank_c) ? in_ch.tank_b - in_ch.tank_c
                                               : in_ch.tank_c - in_ch.tank_b;
        dac    = (in_ch.tank_a > in_ch.tank_c) ? in_ch.tank_a - in_ch.tank_c
                                               : in_ch.tank_c - in_ch.tank_a;
        sum_ab = {1'b0, in_ch.tank_a} + {1'b0, in_ch.tank_b};
        sum_bc = {1'b0, in_ch.tank_b} + {1'b0, in_ch.tank_c};
        sum_ac = {1'b0, in_ch.tank_a} + {1'b0, in_ch.tank_c};
        if (dab > dbc && dac > dbc)
            fused_now = sum_bc[PRESS_W:1];
        else if (dab > dac && dbc > dac)
            fused_now = sum_ac[PRESS_W:1];
        else
            fused_now = sum_ab[PRESS_W:1];
    end

    // update arithmetic around the shared unit
    assign den        = $signed({1'b0, cfg.supply_start_pressure}) -
                        $signed({1'b0, cfg.limit_pressure});
    assign err_now    = $signed({1'b0, sp_reg}) - $signed({1'b0, fused_reg});
    assign supply_off = $signed({1'b0, supply_reg}) -
                        $signed({1'b0, cfg.supply_start_pressure});
    assign err_diff   = DIFF_W'(err_reg) - prev_reg;
    assign per_div    = (cfg.period_ms == '0) ? GAIN_W'(1) : cfg.period_ms;
    assign res_s      = $signed(rsp.result);

    assign fs_sum = $signed(WIDE_W'(cfg.limit_pressure)) + res_s;
    assign fs_sat = (fs_sum > FS_POS) ? FS_POS : ((fs_sum < FS_NEG) ? FS_NEG : fs_sum);

    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg} + rsp.result[INTEG_W:0];
    always_comb
    begin
        if (integ_sum[INTEG_W:INTEG_W-1] == 2'b01)
            integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
        else if (integ_sum[INTEG_W:INTEG_W-1] == 2'b10)
            integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            integ_sat = integ_sum[INTEG_W-1:0];
    end

    assign iterm_sat  = (res_s > ITERM_POS) ? ITERM_POS
                                            : ((res_s < ITERM_NEG) ? ITERM_NEG : res_s);
    assign fs8        = {{(WIDE_W-FS_W-8){fs_reg[FS_W-1]}}, fs_reg, 8'b0};
    assign corr_shift = {corr_reg[WIDE_W-9:0], 8'b0};
    assign duty_sum   = rsp.result[33:0] + 34'h0FFFF;
    assign duty_now   = duty_sum[31:16];

    // shared unit request
    assign op_state  = (state_reg != ST_IDLE) && (state_reg != ST_ERR) &&
                       (state_reg != ST_DECIDE);
    assign req.start = op_state && !issued_reg;
    always_comb
    begin
        req.op  = MDU_MUL;
        req.opa = '0;
        req.opb = '0;
        case (state_reg)
            ST_RMUL:
            begin
                req.opa = WIDE_W'(tss_reg);
                req.opb = WIDE_W'(cfg.limit_pressure);
            end
            ST_RDIV:
            begin
                req.op  = MDU_DIV;
                req.opa = rsp.result;
                req.opb = WIDE_W'(RAMP_MS);
            end
            ST_FMUL:
            begin
                req.opa = WIDE_W'(supply_off);
                req.opb = WIDE_W'(cfg.limit_pressure);
            end
            ST_FDIV:
            begin
                req.op  = MDU_DIV;
                req.opa = rsp.result;
                req.opb = WIDE_W'(den);
            end
            ST_IMUL:
            begin
                req.opa = WIDE_W'(err_reg);
                req.opb = WIDE_W'(cfg.period_ms);
            end
            ST_DMUL:
            begin
                req.opa = WIDE_W'(err_diff);
                req.opb = WIDE_W'(DERIV_SCALE);
            end
            ST_DDIV:
            begin
                req.op  = MDU_DIV;
                req.opa = rsp.result;
                req.opb = WIDE_W'(per_div);
            end
            ST_TMUL:
            begin
                req.opa = WIDE_W'(integ_reg);
                req.opb = WIDE_W'(cfg.gain_i);
            end
            ST_PMUL:
            begin
                req.opa = WIDE_W'(err_reg);
                req.opb = WIDE_W'(cfg.gain_p);
            end
            ST_GMUL:
            begin
                req.opa = WIDE_W'(deriv_reg);
                req.opb = WIDE_W'(cfg.gain_d);
            end
            ST_QDIV:
            begin
                req.op  = MDU_DIV;
                req.opa = corr_shift;
                req.opb = WIDE_W'(fs_reg);
            end
            ST_WMUL:
            begin
                req.opa = WIDE_W'(ratio_reg);
                req.opb = WIDE_W'(cfg.period_ms);
            end
            default: ;
        endcase
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            tsu_reg       <= '0;
            tss_reg       <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            ramp_reg      <= '0;
            duty_ms_reg   <= '0;
            ratio_reg     <= '0;
            fused_reg     <= '0;
            sp_reg        <= '0;
            supply_reg    <= '0;
            err_reg       <= '0;
            fs_reg        <= '0;
            deriv_reg     <= '0;
            corr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_valve_reg <= 1'b0;
            out_upd_reg   <= 1'b0;
            out_fused_reg <= '0;
            out_sp_reg    <= '0;
            out_duty_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            if (rsp.done)
                issued_reg <= 1'b0;
            else if (req.start)
                issued_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        tss_reg <= tss_inc;
                        if (due)
                        begin
                            tsu_reg    <= '0;
                            fused_reg  <= fused_now;
                            supply_reg <= in_ch.supply_pressure;
                            if (cfg.mode_select && (ramp_reg < cfg.limit_pressure))
                                state_reg <= ST_RMUL;
                            else
                            begin
                                sp_reg <= cfg.limit_pressure;
                                if (cfg.mode_select)
                                    ramp_reg <= cfg.limit_pressure;
                                state_reg <= ST_ERR;
                            end
                        end
                        else
                        begin
                            tsu_reg       <= tsu_inc;
                            out_valid_reg <= 1'b1;
                            out_valve_reg <= tsu_inc < {1'b0, duty_ms_reg};
                            out_upd_reg   <= 1'b0;
                            out_fused_reg <= fused_reg;
                            out_sp_reg    <= sp_reg;
                            out_duty_reg  <= ratio_reg;
                        end
                    end
                end
                ST_RMUL:
                    if (rsp.done)
                        state_reg <= ST_RDIV;
                ST_RDIV:
                begin
                    // ramp target never passes the limit
                    if (rsp.done)
                    begin
                        if (rsp.result < WIDE_W'(cfg.limit_pressure))
                        begin
                            ramp_reg <= rsp.result[PRESS_W-1:0];
                            sp_reg   <= rsp.result[PRESS_W-1:0];
                        end
                        else
                        begin
                            ramp_reg <= cfg.limit_pressure;
                            sp_reg   <= cfg.limit_pressure;
                        end
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR:
                begin
                    err_reg <= err_now;
                    // start pressure equal to limit: no supply scaling
                    if (den == '0)
                    begin
                        fs_reg    <= FS_W'(cfg.limit_pressure);
                        state_reg <= ST_IMUL;
                    end
                    else
                        state_reg <= ST_FMUL;
                end
                ST_FMUL:
                    if (rsp.done)
                        state_reg <= ST_FDIV;
                ST_FDIV:
                begin
                    if (rsp.done)
                    begin
                        fs_reg    <= FS_W'(fs_sat);
                        state_reg <= ST_IMUL;
                    end
                end
                ST_IMUL:
                begin
                    if (rsp.done)
                    begin
                        integ_reg <= integ_sat;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_DMUL:
                    if (rsp.done)
                        state_reg <= ST_DDIV;
                ST_DDIV:
                begin
                    if (rsp.done)
                    begin
                        deriv_reg <= rsp.result[DERIV_W-1:0];
                        state_reg <= ST_TMUL;
                    end
                end
                ST_TMUL:
                begin
                    if (rsp.done)
                    begin
                        corr_reg  <= iterm_sat;
                        state_reg <= ST_PMUL;
                    end
                end
                ST_PMUL:
                begin
                    if (rsp.done)
                    begin
                        corr_reg  <= corr_reg + res_s;
                        state_reg <= ST_GMUL;
                    end
                end
                ST_GMUL:
                begin
                    if (rsp.done)
                    begin
                        corr_reg  <= corr_reg + res_s;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    // clamp to 0..1, negative correction also drops the integral
                    if (corr_reg > fs8)
                    begin
                        ratio_reg <= RATIO_FULL;
                        state_reg <= ST_WMUL;
                    end
                    else if (corr_reg[WIDE_W-1])
                    begin
                        ratio_reg <= '0;
                        integ_reg <= '0;
                        state_reg <= ST_WMUL;
                    end
                    else if (fs_reg[FS_W-1] || (fs_reg == '0))
                    begin
                        ratio_reg <= '0;
                        state_reg <= ST_WMUL;
                    end
                    else
                        state_reg <= ST_QDIV;
                end
                ST_QDIV:
                begin
                    if (rsp.done)
                    begin
                        ratio_reg <= rsp.result[DUTY_W-1:0];
                        state_reg <= ST_WMUL;
                    end
                end
                ST_WMUL:
                begin
                    // duty time rounded up, then the update tick result
                    if (rsp.done)
                    begin
                        duty_ms_reg   <= duty_now;
                        prev_reg      <= DIFF_W'(err_reg);
                        out_valid_reg <= 1'b1;
                        out_valve_reg <= (duty_now != '0);
                        out_upd_reg   <= 1'b1;
                        out_fused_reg <= fused_reg;
                        out_sp_reg    <= sp_reg;
                        out_duty_reg  <= ratio_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    `PRPP_ASSERT(a_mdu_start_idle, clk, rst_n, req.start |-> !rsp.busy, "unit started while busy")
    `PRPP_ASSERT(a_ratio_range, clk, rst_n, ratio_reg <= RATIO_FULL, "duty ratio above full")
    `PRPP_ASSERT_NEXT(a_plain_tick, clk, rst_n, in_acc && !due, out_valid_reg && !out_upd_reg, "plain tick gave no result")
    `PRPP_ASSERT(a_upd_count, clk, rst_n, (out_valid_reg && out_upd_reg) |-> (tsu_reg == '0), "update result with nonzero count")

endmodule

FILE: hdl/pressure_regulator_pid_pwm_unit.sv
// ----------------------------------------------------------------------------
// Pressure regulator PID/PWM unit
// Tick-driven tank pressure PID with PWM valve output and APB configuration.
// ----------------------------------------------------------------------------
// A tick without a control update yields its registered result in the cycle after
// transfer. A tick with an update runs up to 8 multiplies and 4 divides, one after
// another, on the shared multiply/divide unit. One tick at a time: no new tick is
// taken until its result is registered and the output is empty or being taken.
// Reset (rst_n low, asynchronous): counters, PID state and outputs clear, registers
// return to their default values.
module pressure_regulator_pid_pwm_unit import prpp_pkg::*;
#(
    parameter int RAMP_MS = 10000
)
(
    input  logic        clk,
    input  logic        rst_n,
    prpp_in_if.sink     in_ch,
    prpp_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    prpp_cfg_t     cfg;
    prpp_mdu_req_t mdu_req;
    prpp_mdu_rsp_t mdu_rsp;

    // configuration registers
    prpp_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared multiply/divide unit
    prpp_mdu u_mdu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .rsp   (mdu_rsp)
    );

    // control sequencer
    prpp_core #(
        .RAMP_MS (RAMP_MS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .req    (mdu_req),
        .rsp    (mdu_rsp)
    );

endmodule
